>>> rtl/round_robin_mutex_handoff_unit_defines.svh
// assertion macros for the round-robin mutex handoff unit
`ifndef ROUND_ROBIN_MUTEX_HANDOFF_UNIT_DEFINES_SVH
`define ROUND_ROBIN_MUTEX_HANDOFF_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RRMH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrmh check failed");

// implication checked in the next cycle
`define RRMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrmh check failed");

`endif

>>> rtl/rrmh_pkg.sv
// shared types and constants of the round-robin mutex handoff unit
package rrmh_pkg;

  localparam int REQ_W  = 4;
  localparam int PART_W = 5;

  localparam logic [PART_W-1:0] PART_RESET = 5'd16;

  typedef enum logic {
    KIND_LOCK   = 1'b0,
    KIND_UNLOCK = 1'b1
  } kind_t;

  // outcome of the round-robin search
  typedef struct packed {
    logic             found;
    logic [REQ_W-1:0] holder;
  } pick_t;

endpackage

>>> rtl/rrmh_search.sv
// round-robin pick of the next set request bit after the requester
module rrmh_search import rrmh_pkg::*; #(
  parameter int MAX_PARTICIPANTS = 16
) (
  input  logic [MAX_PARTICIPANTS-1:0] cand,
  input  logic [REQ_W-1:0]            requester,
  output pick_t                       pick
);

  localparam int IW = (MAX_PARTICIPANTS > 2) ? $clog2(MAX_PARTICIPANTS) : 1;

  logic [MAX_PARTICIPANTS-1:0] above;
  logic [MAX_PARTICIPANTS-1:0] upper;
  logic [MAX_PARTICIPANTS-1:0] pool;
  logic [MAX_PARTICIPANTS-1:0] first;
  logic [IW-1:0]               idx;

  always_comb begin
    for (int i = 0; i < MAX_PARTICIPANTS; i++) begin
      above[i] = (i > int'(requester));
    end
    upper = cand & above;
    // wrap to the bottom when nothing waits above the requester
    pool  = (|upper) ? upper : cand;
    first = pool & (~pool + {{(MAX_PARTICIPANTS-1){1'b0}}, 1'b1});
    idx   = '0;
    for (int i = 0; i < MAX_PARTICIPANTS; i++) begin
      if (first[i]) begin
        idx = idx | IW'(i);
      end
    end
    pick.found  = |cand;
    pick.holder = REQ_W'(idx);
  end

endmodule

>>> rtl/round_robin_mutex_handoff_unit.sv
// top level of the round-robin mutex handoff unit
//
// hardware mutex kept as one request bit per participant. a lock word sets
// the requester's bit and reports granted when no other active bit was set;
// an unlock word clears the requester's bit and hands the lock to the next
// set bit found round-robin from requester+1, wrapping at the participant
// count. one word is taken every cycle (busy is low except during reset and
// the cycle after it); done rises one cycle after its word is taken, holds the
// result for exactly one cycle and must be captured at the edge that ends it,
// since there is no back-pressure. throughput is set by the single
// request-vector update per cycle: the input register feeds the mask and
// search logic, which writes the request bits and the result register at the
// same edge, so the next word always sees the previous word's update. the
// participant count (2 to MAX_PARTICIPANTS, values outside clamped) is written
// through cfg_we/cfg_wdata, by the user only while the unit is idle (unchecked).
// a requester >= count leaves the state alone: granted 0, handoff 0, own index.
module round_robin_mutex_handoff_unit import rrmh_pkg::*; #(
  parameter int MAX_PARTICIPANTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [REQ_W-1:0]  requester,
  input  logic              cfg_we,
  input  logic [PART_W-1:0] cfg_wdata,
  output logic              done,
  output logic              granted,
  output logic              handoff,
  output logic [REQ_W-1:0]  next_holder
);

  // wide enough for both the register and the clamp limit
  localparam int NW = $clog2(MAX_PARTICIPANTS + 1);
  localparam int CW = (NW > PART_W) ? NW : PART_W;

  // configuration
  logic [PART_W-1:0] participants;

  // input register
  logic              valid;
  kind_t             kind_q;
  logic [REQ_W-1:0]  req_q;

  // request vector
  logic [MAX_PARTICIPANTS-1:0] request_bits;
  logic [MAX_PARTICIPANTS-1:0] request_bits_next;

  // working signals
  logic [CW-1:0]               part_ext;
  logic [CW-1:0]               count;
  logic                        req_ok;
  logic [MAX_PARTICIPANTS-1:0] active;
  logic [MAX_PARTICIPANTS-1:0] own;
  logic [MAX_PARTICIPANTS-1:0] others;
  pick_t                       pick;
  logic                        granted_next;
  logic                        handoff_next;
  logic [REQ_W-1:0]            holder_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      participants <= PART_RESET;
    end else if (cfg_we) begin
      participants <= cfg_wdata;
    end
  end

  // busy covers reset and the first cycle out of it
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_q <= kind_t'(kind);
      req_q  <= requester;
    end
  end

  // clamp the participant count and build the masks
  always_comb begin
    part_ext = CW'(participants);
    if (part_ext < CW'(2)) begin
      count = CW'(2);
    end else if (part_ext > CW'(MAX_PARTICIPANTS)) begin
      count = CW'(MAX_PARTICIPANTS);
    end else begin
      count = part_ext;
    end
    req_ok = CW'(req_q) < count;
    for (int i = 0; i < MAX_PARTICIPANTS; i++) begin
      active[i] = CW'(i) < count;
      own[i]    = (i == int'(req_q));
    end
    // bits at or above the count are kept but masked out of the grant and search
    others = request_bits & active & ~own;
  end

  rrmh_search #(
    .MAX_PARTICIPANTS(MAX_PARTICIPANTS)
  ) u_search (
    .cand     (others),
    .requester(req_q),
    .pick     (pick)
  );

  always_comb begin
    request_bits_next = request_bits;
    granted_next      = 1'b0;
    handoff_next      = 1'b0;
    holder_next       = req_q;
    if (valid && req_ok) begin
      case (kind_q)
        KIND_LOCK: begin
          granted_next      = ~|others;
          request_bits_next = request_bits | own;
        end
        KIND_UNLOCK: begin
          request_bits_next = request_bits & ~own;
          handoff_next      = pick.found;
          if (pick.found) begin
            holder_next = pick.holder;
          end
        end
        default: begin
          request_bits_next = request_bits;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_bits <= '0;
      done         <= 1'b0;
    end else begin
      request_bits <= request_bits_next;
      done         <= valid;
    end
  end

  // result register, one word per done strobe
  always_ff @(posedge clk) begin
    granted     <= granted_next;
    handoff     <= handoff_next;
    next_holder <= holder_next;
  end

endmodule

>>> rtl/rrmh_checker.sv
// port-level checker of the round-robin mutex handoff unit and its bind
`include "round_robin_mutex_handoff_unit_defines.svh"

module rrmh_checker import rrmh_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [REQ_W-1:0]  requester,
  input logic              done,
  input logic              granted,
  input logic              handoff,
  input logic [REQ_W-1:0]  next_holder
);

  logic taken;

  assign taken = start && !busy;

  // every taken word gives one result, through the valid and done registers
  `RRMH_ASSERT_NEXT(a_result_follows, taken, ##1 done)
  // no result without a taken word that has passed the valid and done registers
  `RRMH_ASSERT_NOW(a_no_stray_result, done, $past(taken, 2))
  // a result never both grants and hands off
  `RRMH_ASSERT_NOW(a_grant_xor_handoff, done, !(granted && handoff))
  // without a handoff the holder field echoes the requester
  `RRMH_ASSERT_NOW(a_holder_echo, done && !handoff, next_holder == $past(requester, 2))

endmodule

bind round_robin_mutex_handoff_unit rrmh_checker u_rrmh_checker (.*);

>>> tb/tb.sv
// self-checking testbench for the round-robin mutex handoff unit
`timescale 1ns / 100ps

module tb;
  import rrmh_pkg::*;

  localparam int MAX_PART        = 16;
  localparam int STALL_LIMIT     = 1000;  // cycles with no word in and no result out
  localparam int WORDS_PER_PHASE = 120;
  localparam int PHASES          = 10;
  localparam int REPORT_LIMIT    = 10;

  // count settings for the first random phases: reset value, clamp extremes, both ends
  localparam logic [6*PART_W-1:0] EDGE_COUNTS =
    {5'd16, 5'd0, 5'd17, 5'd1, 5'd31, 5'd2};

  typedef struct packed {
    logic             granted;
    logic             handoff;
    logic [REQ_W-1:0] next_holder;
  } outcome_t;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_CFG  = 1'b1
  } row_op_t;

  // one line of the directed script
  typedef struct packed {
    row_op_t           op;
    kind_t             kind;
    logic [REQ_W-1:0]  req;
    logic [PART_W-1:0] count;
    logic              typed;   // want holds a hand-written expectation
    outcome_t          want;
  } script_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  kind_t             kind;
  logic [REQ_W-1:0]  requester;
  logic              cfg_we;
  logic [PART_W-1:0] cfg_wdata;
  logic              done;
  logic              granted;
  logic              handoff;
  logic [REQ_W-1:0]  next_holder;

  // predictor state: the count register and the request vector
  logic [PART_W-1:0]   count_reg;
  logic [MAX_PART-1:0] lock_bits;

  outcome_t    pending_outcomes[$];
  script_row_t script[$];
  int          mismatches;
  int          idle_cycles;

  round_robin_mutex_handoff_unit #(
    .MAX_PARTICIPANTS(MAX_PART)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .requester   (requester),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .granted     (granted),
    .handoff     (handoff),
    .next_holder (next_holder)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // count register as the block sees it: clamped to 2..MAX_PART
  function automatic int active_count();
    int n;
    n = int'(count_reg);
    if (n < 2) n = 2;
    if (n > MAX_PART) n = MAX_PART;
    return n;
  endfunction

  // outcome of one word, with the request vector updated in place
  function automatic outcome_t resolve_word(kind_t k, logic [REQ_W-1:0] req);
    outcome_t      o;
    int            n;
    int            cand;
    logic [31:0]   span;
    logic [MAX_PART-1:0] others;
    o.granted     = 1'b0;
    o.handoff     = 1'b0;
    o.next_holder = req;
    n = active_count();
    // a requester outside the active range leaves everything alone
    if (int'(req) < n) begin
      span   = (32'd1 << n) - 32'd1;
      others = lock_bits & span[MAX_PART-1:0];
      others[req] = 1'b0;
      if (k == KIND_LOCK) begin
        o.granted      = (others == '0);
        lock_bits[req] = 1'b1;
      end else begin
        lock_bits[req] = 1'b0;
        // first set bit after the requester, wrapping at the count
        for (int i = 1; i < n; i++) begin
          cand = (int'(req) + i) % n;
          if (!o.handoff && others[cand]) begin
            o.handoff     = 1'b1;
            o.next_holder = cand[REQ_W-1:0];
          end
        end
      end
    end
    return o;
  endfunction

  function automatic void add_word(kind_t k, logic [REQ_W-1:0] r);
    script_row_t row;
    row      = '0;
    row.op   = ROW_WORD;
    row.kind = k;
    row.req  = r;
    script.push_back(row);
  endfunction

  // word whose outcome is obvious from the vector contents
  function automatic void add_checked(kind_t k, logic [REQ_W-1:0] r, logic g, logic h,
                                      logic [REQ_W-1:0] nh);
    script_row_t row;
    row                  = '0;
    row.op               = ROW_WORD;
    row.kind             = k;
    row.req              = r;
    row.typed            = 1'b1;
    row.want.granted     = g;
    row.want.handoff     = h;
    row.want.next_holder = nh;
    script.push_back(row);
  endfunction

  function automatic void add_cfg(logic [PART_W-1:0] c);
    script_row_t row;
    row       = '0;
    row.op    = ROW_CFG;
    row.count = c;
    script.push_back(row);
  endfunction

  // stop sending and let every outstanding result come back, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // register writes only happen with the unit empty
  task automatic write_count(input logic [PART_W-1:0] val);
    drain();
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    count_reg  = val;
  endtask

  // entered and left just after a falling edge; start stays high between back-to-back words
  task automatic send_word(input kind_t k, input logic [REQ_W-1:0] r, input int gap,
                           input logic typed, input outcome_t want);
    outcome_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    kind      <= k;
    requester <= r;
    // busy only moves on a rising edge, so its value here holds through the next one
    while (busy) @(negedge clk);
    @(posedge clk);
    predicted = resolve_word(k, r);
    pending_outcomes.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // result checker: the unit cannot stall results, so every done pulse is taken
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: granted %0d handoff %0d next_holder %0d",
                   granted, handoff, next_holder);
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (granted !== exp_o.granted || handoff !== exp_o.handoff ||
            next_holder !== exp_o.next_holder) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: expected g %0d h %0d next %0d, got g %0d h %0d next %0d",
                     exp_o.granted, exp_o.handoff, exp_o.next_holder,
                     granted, handoff, next_holder);
        end
      end
    end
  end

  // watchdog: any accepted word or result restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          n;
    int          counted;
    int          roll;
    int          gap;
    bit          quiet;
    kind_t       k;
    logic [REQ_W-1:0] r;
    script_row_t row;

    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_LOCK;
    requester   = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    count_reg   = PART_RESET;
    lock_bits   = '0;
    mismatches  = 0;
    idle_cycles = 0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (busy) @(negedge clk);

    // directed part, count at its reset value of 16
    add_checked(KIND_LOCK,   4'd0,  1'b1, 1'b0, 4'd0);   // first lock on an empty vector
    add_checked(KIND_LOCK,   4'd15, 1'b0, 1'b0, 4'd15);  // top participant has to wait
    add_word   (KIND_LOCK,   4'd7);
    add_word   (KIND_LOCK,   4'd7);                      // repeat lock, own bit already set
    add_checked(KIND_UNLOCK, 4'd0,  1'b0, 1'b1, 4'd7);   // handoff to the nearest waiter
    add_word   (KIND_UNLOCK, 4'd7);
    add_checked(KIND_UNLOCK, 4'd15, 1'b0, 1'b0, 4'd15);  // last holder, nobody waiting
    add_word   (KIND_UNLOCK, 4'd3);                      // release without holding
    add_checked(KIND_LOCK,   4'd15, 1'b1, 1'b0, 4'd15);
    add_checked(KIND_UNLOCK, 4'd15, 1'b0, 1'b0, 4'd15);
    // four participants: out-of-range requesters and a wrapping search
    add_cfg    (5'd4);
    add_checked(KIND_LOCK,   4'd5,  1'b0, 1'b0, 4'd5);
    add_word   (KIND_LOCK,   4'd3);
    add_word   (KIND_LOCK,   4'd1);
    add_checked(KIND_UNLOCK, 4'd3,  1'b0, 1'b1, 4'd1);
    add_checked(KIND_LOCK,   4'd15, 1'b0, 1'b0, 4'd15);
    // a count of zero acts as two
    add_cfg    (5'd0);
    add_checked(KIND_LOCK,   4'd2,  1'b0, 1'b0, 4'd2);
    add_word   (KIND_LOCK,   4'd1);
    add_word   (KIND_LOCK,   4'd0);
    add_word   (KIND_UNLOCK, 4'd1);
    // a count above the maximum acts as the maximum
    add_cfg    (5'd31);
    add_word   (KIND_LOCK,   4'd12);
    add_word   (KIND_UNLOCK, 4'd0);
    add_word   (KIND_UNLOCK, 4'd12);

    for (int i = 0; i < script.size(); i++) begin
      row = script[i];
      if (row.op == ROW_CFG)
        write_count(row.count);
      else
        send_word(row.kind, row.req, $urandom_range(0, 5), row.typed, row.want);
    end

    // random phases, each under its own participant count
    for (int p = 0; p < PHASES; p++) begin
      if (p < 6)
        write_count(EDGE_COUNTS[p*PART_W +: PART_W]);
      else
        write_count(PART_W'($urandom_range(2, MAX_PART)));
      n       = active_count();
      counted = 0;
      quiet   = 1'b0;
      while (counted < WORDS_PER_PHASE) begin
        // stretches with back-to-back words
        if (counted % 40 == 0)
          quiet = ($urandom_range(0, 2) == 0);
        // occasionally let the unit run dry before going on
        if ($urandom_range(0, 99) == 0)
          drain();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: any requester, any kind
          r = REQ_W'($urandom_range(0, MAX_PART - 1));
          k = kind_t'($urandom_range(0, 1));
        end else begin
          // mostly lock when not queued, release when queued or holding
          r = REQ_W'($urandom_range(0, n - 1));
          if (lock_bits[r])
            k = (roll < 90) ? KIND_UNLOCK : KIND_LOCK;
          else
            k = (roll < 90) ? KIND_LOCK : KIND_UNLOCK;
        end
        gap = quiet ? 0 : $urandom_range(0, 5);
        send_word(k, r, gap, 1'b0, '0);
        if (int'(r) < n) counted++;
      end
    end

    drain();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rrmh_pkg.sv
rtl/rrmh_search.sv
rtl/round_robin_mutex_handoff_unit.sv
rtl/rrmh_checker.sv
tb/tb.sv
